/* hw/rtl/sovg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sovg_pkg
// Shared constants, types and planning functions for the outline generator.
// ----------------------------------------------------------------------------
package sovg_pkg;

    localparam int MAX_POINTS      = 64;
    localparam int TRIG_ITERATIONS = 16;
    localparam int DIV_STEPS       = 33;

    localparam int KIND_W = 3;
    localparam int DIA_W  = 16;
    localparam int RES_W  = 7;
    localparam int CRD_W  = 17;
    localparam int FAC_W  = 34;
    localparam int PRD_W  = 51;
    localparam int DEN_W  = 10;
    localparam int IDX_W  = 6;
    localparam int TW     = 11;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_CIRCLE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SQUARE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RECT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_THIRD   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_HALF    = 3'd5;

    localparam logic [1:0] DSEL_R1 = 2'd0;
    localparam logic [1:0] DSEL_R2 = 2'd1;
    localparam logic [1:0] DSEL_R4 = 2'd2;

    localparam logic signed [FAC_W-1:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [FAC_W-1:0] Q30_HALF    = 34'sd536870912;
    localparam logic signed [FAC_W-1:0] Q30_QUARTER = 34'sd268435456;
    localparam logic signed [FAC_W-1:0] Q30_HS3     = 34'sd929887697;
    localparam logic signed [FAC_W-1:0] CORDIC_START      = 34'sd652032874;
    localparam logic signed [FAC_W-1:0] CORDIC_START_HALF = 34'sd326016437;

    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                     is_const;
        logic signed [FAC_W-1:0]  cval;
        logic                     use_s3;
        logic signed [TW-1:0]     t;
        logic [1:0]               dsel;
    } t_comp;

    typedef struct packed {
        logic                 polar;
        logic                 half;
        logic signed [TW-1:0] k;
        t_comp                xc;
        t_comp                yc;
    } t_plan;

    function automatic logic [RES_W-1:0] sovg_div3(input logic [7:0] n);
        logic [15:0] p;
        p = 16'(n) * 16'd171;
        return p[15:9];
    endfunction

    function automatic t_comp comp_const(input logic signed [FAC_W-1:0] v);
        t_comp c;
        c          = '0;
        c.is_const = 1'b1;
        c.cval     = v;
        return c;
    endfunction

    function automatic t_comp comp_rd(input logic s3, input logic signed [TW-1:0] t,
                                      input logic [1:0] dsel);
        t_comp c;
        c        = '0;
        c.use_s3 = s3;
        c.t      = t;
        c.dsel   = dsel;
        return c;
    endfunction

    function automatic logic [RES_W-1:0] sovg_seg_count(input logic [KIND_W-1:0] kind,
                                                       input logic [1:0] seg,
                                                       input logic [RES_W-1:0] r);
        logic [RES_W-1:0] s4;
        logic [RES_W-1:0] s3;
        logic [RES_W-1:0] s23;
        logic [RES_W-1:0] cnt;
        s4  = r >> 2;
        s3  = sovg_div3({1'b0, r});
        s23 = sovg_div3({r, 1'b0});
        cnt = '0;
        case (kind)
            KIND_CIRCLE:             cnt = (seg == 2'd0) ? r : '0;
            KIND_SQUARE, KIND_RECT:  cnt = s4;
            KIND_TRIANGLE:           cnt = (seg == 2'd3) ? '0 : s3;
            KIND_THIRD:              cnt = (seg == 2'd2) ? (r >> 1) :
                                           ((seg == 2'd3) ? '0 : s4);
            KIND_HALF:               cnt = (seg == 2'd0) ? s3 :
                                           ((seg == 2'd1) ? s23 : '0);
            default:                 cnt = '0;
        endcase
        return cnt;
    endfunction

    function automatic logic [RES_W-1:0] sovg_total(input logic [KIND_W-1:0] kind,
                                                   input logic [RES_W-1:0] r);
        logic [RES_W-1:0] s4;
        logic [RES_W-1:0] s3;
        logic [RES_W-1:0] tot;
        s4  = r >> 2;
        s3  = sovg_div3({1'b0, r});
        tot = '0;
        case (kind)
            KIND_CIRCLE:            tot = r;
            KIND_SQUARE, KIND_RECT: tot = {s4[4:0], 2'b00};
            KIND_TRIANGLE:          tot = s3 + {s3[5:0], 1'b0};
            KIND_THIRD:             tot = {s4[5:0], 1'b0} + (r >> 1);
            KIND_HALF:              tot = s3 + sovg_div3({r, 1'b0});
            default:                tot = '0;
        endcase
        return tot;
    endfunction

    function automatic t_plan sovg_plan(input logic [KIND_W-1:0] kind,
                                        input logic [1:0] seg,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [RES_W-1:0] r);
        logic signed [TW-1:0]    ri;
        logic signed [TW-1:0]    ii;
        logic [1:0]              yd;
        logic signed [FAC_W-1:0] yc;
        t_plan                   p;
        ri = $signed({4'b0, r});
        ii = $signed({5'b0, idx});
        yd = (kind == KIND_SQUARE) ? DSEL_R2 : DSEL_R4;
        yc = (kind == KIND_SQUARE) ? Q30_HALF : Q30_QUARTER;
        p  = '0;
        p.xc = comp_const('0);
        p.yc = comp_const('0);
        case (kind)
            KIND_CIRCLE: begin
                p.polar = 1'b1;
                p.half  = 1'b1;
                p.k     = (ii <<< 3) + (ii <<< 2);
            end
            KIND_SQUARE, KIND_RECT: begin
                case (seg)
                    2'd0: begin
                        p.xc = comp_const(Q30_HALF);
                        p.yc = comp_rd(1'b0, (ii <<< 3) - ri, yd);
                    end
                    2'd1: begin
                        p.xc = comp_rd(1'b0, ri - (ii <<< 3), DSEL_R2);
                        p.yc = comp_const(yc);
                    end
                    2'd2: begin
                        p.xc = comp_const(-Q30_HALF);
                        p.yc = comp_rd(1'b0, ri - (ii <<< 3), yd);
                    end
                    default: begin
                        p.xc = comp_rd(1'b0, (ii <<< 3) - ri, DSEL_R2);
                        p.yc = comp_const(-yc);
                    end
                endcase
            end
            KIND_TRIANGLE: begin
                case (seg)
                    2'd0: begin
                        p.xc = comp_rd(1'b0, (ri <<< 1) - (ii <<< 3) - ii, DSEL_R2);
                        p.yc = comp_rd(1'b1, (ii <<< 1) + ii, DSEL_R1);
                    end
                    2'd1: begin
                        p.xc = comp_const(-Q30_HALF);
                        p.yc = comp_rd(1'b1, ri - (ii <<< 2) - (ii <<< 1), DSEL_R1);
                    end
                    default: begin
                        p.xc = comp_rd(1'b0, (ii <<< 3) + ii - ri, DSEL_R2);
                        p.yc = comp_rd(1'b1, (ii <<< 1) + ii - ri, DSEL_R1);
                    end
                endcase
            end
            KIND_THIRD: begin
                case (seg)
                    2'd0: begin
                        p.yc = comp_rd(1'b0, ri - (ii <<< 2), DSEL_R1);
                    end
                    2'd1: begin
                        p.xc = comp_rd(1'b1, ii <<< 2, DSEL_R1);
                        p.yc = comp_rd(1'b0, -(ii <<< 1), DSEL_R1);
                    end
                    default: begin
                        p.polar = 1'b1;
                        p.k     = (ii <<< 3) - ri;
                    end
                endcase
            end
            KIND_HALF: begin
                if (seg == 2'd0) begin
                    p.yc = comp_rd(1'b0, ri - (ii <<< 2) - (ii <<< 1), DSEL_R1);
                end else begin
                    p.polar = 1'b1;
                    p.k     = (ii <<< 3) + ii - (ri <<< 1) - ri;
                end
            end
            default: begin
                p.polar = 1'b0;
            end
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/shape_outline_vertex_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shape_outline_vertex_generator
// Turns a shape request into a run of outline vertices in signed Q9.8.
// ----------------------------------------------------------------------------
// One request is taken when the block is idle; its vertices then leave one
// word each, the final one with tlast. Every divided coefficient and every
// angle goes through one shared 33-step restoring divider, arc points add
// 16 steps of a shared CORDIC rotator, and one shared multiplier scales both
// coordinates. An undefined kind or a resolution too small for the shape
// returns one zero word with tuser and tlast set.
module shape_outline_vertex_generator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    // [15:0] diameter, [22:16] resolution, [23] zero
    input  wire logic [sovg_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [2:0] shape_kind
    input  wire logic [sovg_pkg::KIND_W-1:0]   s_axis_tuser,
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [16:0] vertex_x, [33:17] vertex_y, [39:34] zero
    output      logic [sovg_pkg::M_DATA_W-1:0] m_axis_tdata,
    output      logic                          m_axis_tlast,
    // [0] no_vertices
    output      logic                          m_axis_tuser
);
    import sovg_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PLAN  = 4'd1;
    localparam logic [3:0] ST_COMP  = 4'd2;
    localparam logic [3:0] ST_DLOAD = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_DEND  = 4'd5;
    localparam logic [3:0] ST_CORD  = 4'd6;
    localparam logic [3:0] ST_CQUAD = 4'd7;
    localparam logic [3:0] ST_MULX  = 4'd8;
    localparam logic [3:0] ST_RNDX  = 4'd9;
    localparam logic [3:0] ST_RNDY  = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);
    localparam logic [5:0] CORD_LAST = 6'(TRIG_ITERATIONS - 1);

    logic [3:0]               r_state;
    logic [3:0]               n_state;
    logic [KIND_W-1:0]        r_kind;
    logic [DIA_W-1:0]         r_dia;
    logic [RES_W-1:0]         r_res;
    logic [1:0]               r_seg;
    logic [RES_W-1:0]         r_idx;
    logic [RES_W-1:0]         r_emit;
    logic [RES_W-1:0]         r_total;
    logic                     r_comp;
    logic                     r_polar;
    logic                     r_empty;
    logic signed [FAC_W-1:0]  r_fx;
    logic signed [FAC_W-1:0]  r_fy;
    logic signed [PRD_W-1:0]  r_prod;
    logic [DIV_STEPS-1:0]     r_dn;
    logic [DEN_W-1:0]         r_rem;
    logic [DEN_W-1:0]         r_dd;
    logic                     r_neg;
    logic [5:0]               r_cnt;
    logic [1:0]               r_quad;
    logic signed [FAC_W-1:0]  r_cx;
    logic signed [FAC_W-1:0]  r_cy;
    logic signed [FAC_W-1:0]  r_cz;
    logic [CRD_W-1:0]         r_ox;
    logic [CRD_W-1:0]         r_oy;

    logic [RES_W-1:0]         in_res;
    logic [RES_W-1:0]         in_total;
    logic                     s_hs;
    logic                     m_hs;
    logic                     is_last;
    t_plan                    plan;
    t_comp                    spec;
    logic [RES_W-1:0]         seg_cnt;
    logic [DEN_W-1:0]         den;
    logic [DEN_W-1:0]         den12;
    logic [DEN_W-1:0]         ang_m;
    logic [42:0]              ang_n;
    logic [PRD_W-1:0]         prod_mag;
    logic [42:0]              rd_n;
    logic signed [FAC_W-1:0]  mul_a;
    logic signed [CRD_W-1:0]  mul_b;
    logic signed [PRD_W-1:0]  mul_p;
    logic [DEN_W:0]           trial;
    logic                     ge;
    logic [FAC_W-1:0]         quo;
    logic signed [FAC_W-1:0]  quo_s;
    logic [31:0]              ang;
    logic [1:0]               quad;
    logic [31:0]              z32;
    logic [4:0]               sh;
    logic signed [FAC_W-1:0]  xs;
    logic signed [FAC_W-1:0]  ys;
    logic signed [FAC_W-1:0]  atan_v;
    logic [PRD_W-1:0]         rnd_sum;
    logic [20:0]              rnd_v;
    logic [15:0]              rnd_sat;
    logic [CRD_W-1:0]         rnd_out;

    assign in_res   = (s_axis_tdata[22:16] > 7'(MAX_POINTS)) ? 7'(MAX_POINTS)
                                                             : s_axis_tdata[22:16];
    assign in_total = sovg_total(s_axis_tuser, in_res);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_hs     = s_axis_tvalid && s_axis_tready;
    assign m_hs     = m_axis_tvalid && m_axis_tready;
    assign is_last  = r_empty || ((r_emit + 7'd1) == r_total);

    assign plan    = sovg_plan(r_kind, r_seg, r_idx[IDX_W-1:0], r_res);
    assign spec    = r_comp ? plan.yc : plan.xc;
    assign seg_cnt = sovg_seg_count(r_kind, r_seg, r_res);

    always_comb begin
        case (spec.dsel)
            DSEL_R2: den = {2'b0, r_res, 1'b0};
            DSEL_R4: den = {1'b0, r_res, 2'b0};
            default: den = {3'b0, r_res};
        endcase
    end

    assign den12    = {r_res, 3'b0} + {1'b0, r_res, 2'b0};
    assign ang_m    = plan.k[TW-1] ? (plan.k[DEN_W-1:0] + den12) : plan.k[DEN_W-1:0];
    assign ang_n    = {1'b0, ang_m, 32'b0} + {34'b0, den12[DEN_W-1:1]};
    assign prod_mag = r_prod[PRD_W-1] ? PRD_W'(-r_prod) : PRD_W'(r_prod);
    assign rd_n     = prod_mag[42:0] + {34'b0, den[DEN_W-1:1]};

    // shared multiplier
    always_comb begin
        case (r_state)
            ST_COMP: begin
                mul_a = spec.use_s3 ? Q30_HS3 : Q30_ONE;
                mul_b = CRD_W'(spec.t);
            end
            ST_MULX: begin
                mul_a = r_fx;
                mul_b = $signed({1'b0, r_dia});
            end
            ST_RNDX: begin
                mul_a = r_fy;
                mul_b = $signed({1'b0, r_dia});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = PRD_W'(mul_a) * PRD_W'(mul_b);

    // divider step
    assign trial = {r_rem, r_dn[DIV_STEPS-1]};
    assign ge    = (trial >= {1'b0, r_dd});
    assign quo   = {1'b0, r_dn};
    assign quo_s = r_neg ? -$signed(quo) : $signed(quo);

    // angle fold
    assign ang  = r_dn[31:0];
    assign quad = 2'((ang + 32'h2000_0000) >> 30);
    assign z32  = ang - {quad, 30'b0};

    // rotator step
    assign sh     = r_cnt[4:0];
    assign xs     = r_cx >>> sh;
    assign ys     = r_cy >>> sh;
    assign atan_v = $signed({2'b0, ATAN_TURNS[sh]});

    // scale rounding and clamp
    assign rnd_sum = prod_mag + PRD_W'(32'h2000_0000);
    assign rnd_v   = rnd_sum[50:30];
    assign rnd_sat = (rnd_v > 21'd65535) ? 16'hFFFF : rnd_v[15:0];
    assign rnd_out = r_prod[PRD_W-1] ? CRD_W'(-{1'b0, rnd_sat}) : {1'b0, rnd_sat};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (s_hs) n_state = (in_total == '0) ? ST_OUT : ST_PLAN;
            ST_PLAN:  if (r_idx != seg_cnt) n_state = plan.polar ? ST_DIV : ST_COMP;
            ST_COMP: begin
                if (!spec.is_const) begin
                    n_state = ST_DLOAD;
                end else if (r_comp) begin
                    n_state = ST_MULX;
                end
            end
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV:   if (r_cnt == DIV_LAST) n_state = ST_DEND;
            ST_DEND:  n_state = r_polar ? ST_CORD : (r_comp ? ST_MULX : ST_COMP);
            ST_CORD:  if (r_cnt == CORD_LAST) n_state = ST_CQUAD;
            ST_CQUAD: n_state = ST_MULX;
            ST_MULX:  n_state = ST_RNDX;
            ST_RNDX:  n_state = ST_RNDY;
            ST_RNDY:  n_state = ST_OUT;
            ST_OUT:   if (m_hs) n_state = is_last ? ST_IDLE : ST_PLAN;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_hs) begin
                    r_kind  <= s_axis_tuser;
                    r_dia   <= s_axis_tdata[15:0];
                    r_res   <= in_res;
                    r_total <= in_total;
                    r_seg   <= '0;
                    r_idx   <= '0;
                    r_emit  <= '0;
                    r_empty <= (in_total == '0);
                    r_ox    <= '0;
                    r_oy    <= '0;
                end
            end
            ST_PLAN: begin
                if (r_idx == seg_cnt) begin
                    r_seg <= r_seg + 2'd1;
                    r_idx <= '0;
                end else begin
                    r_polar <= plan.polar;
                    r_comp  <= 1'b0;
                    if (plan.polar) begin
                        r_rem <= ang_n[42:33];
                        r_dn  <= ang_n[32:0];
                        r_dd  <= den12;
                        r_neg <= 1'b0;
                        r_cnt <= '0;
                    end
                end
            end
            ST_COMP: begin
                if (spec.is_const) begin
                    if (r_comp) begin
                        r_fy <= spec.cval;
                    end else begin
                        r_fx   <= spec.cval;
                        r_comp <= 1'b1;
                    end
                end else begin
                    r_prod <= mul_p;
                end
            end
            ST_DLOAD: begin
                r_rem <= rd_n[42:33];
                r_dn  <= rd_n[32:0];
                r_dd  <= den;
                r_neg <= r_prod[PRD_W-1];
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= ge ? DEN_W'(trial - {1'b0, r_dd}) : trial[DEN_W-1:0];
                r_dn  <= {r_dn[DIV_STEPS-2:0], ge};
                r_cnt <= r_cnt + 6'd1;
            end
            ST_DEND: begin
                if (r_polar) begin
                    r_quad <= quad;
                    r_cz   <= FAC_W'($signed(z32));
                    r_cx   <= plan.half ? CORDIC_START_HALF : CORDIC_START;
                    r_cy   <= '0;
                    r_cnt  <= '0;
                end else if (r_comp) begin
                    r_fy <= quo_s;
                end else begin
                    r_fx   <= quo_s;
                    r_comp <= 1'b1;
                end
            end
            ST_CORD: begin
                if (!r_cz[FAC_W-1]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_v;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_v;
                end
                r_cnt <= r_cnt + 6'd1;
            end
            ST_CQUAD: begin
                case (r_quad)
                    2'd0: begin
                        r_fx <= r_cx;
                        r_fy <= r_cy;
                    end
                    2'd1: begin
                        r_fx <= -r_cy;
                        r_fy <= r_cx;
                    end
                    2'd2: begin
                        r_fx <= -r_cx;
                        r_fy <= -r_cy;
                    end
                    default: begin
                        r_fx <= r_cy;
                        r_fy <= -r_cx;
                    end
                endcase
            end
            ST_MULX: r_prod <= mul_p;
            ST_RNDX: begin
                r_ox   <= rnd_out;
                r_prod <= mul_p;
            end
            ST_RNDY: r_oy <= rnd_out;
            ST_OUT: begin
                if (m_hs && !is_last) begin
                    r_idx  <= r_idx + 7'd1;
                    r_emit <= r_emit + 7'd1;
                end
            end
            default: r_cnt <= '0;
        endcase
    end

    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {6'b0, r_oy, r_ox};
    assign m_axis_tlast  = is_last;
    assign m_axis_tuser  = r_empty;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output sides active together");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_dd))
        else $error("divider remainder out of range");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("empty word not final or not zero");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (r_emit < r_total))
        else $error("vertex count beyond shape total");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shape outline vertex generator: shape requests
// go in through a queue-fed driver, each accepted request is expanded by a
// local outline predictor (floor-divided segments, fixed-length CORDIC), and
// every output word is compared in order with the expected vertex run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sovg_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 3'd6;
    localparam int  WATCHDOG_LIMIT = 40000;
    localparam longint Q30 = 64'sd1073741824;
    localparam longint HS3 = 64'sd929887697;
    localparam longint START_GAIN = 64'sd652032874;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [DIA_W-1:0]  dia;
        logic [RES_W-1:0]  res;
    } request_t;

    typedef struct {
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic             last;
        logic             empty;
    } vertex_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [KIND_W-1:0]   s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;

    request_t pending_reqs[$];
    vertex_t  expected_verts[$];
    int       mismatches = 0;
    int       req_gap = 0;
    int       stall_left = 0;
    int       idle_cycles = 0;
    logic     req_taken = 1'b0;
    logic     calm = 1'b0;

    shape_outline_vertex_generator uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint rdiv(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 60) return 0;
        if (p < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    function automatic void emit_point(longint d, longint fx, longint fy);
        vertex_t v;
        longint  x;
        longint  y;
        x = rdiv(d * fx, Q30);
        y = rdiv(d * fy, Q30);
        if (x > 65535) x = 65535;
        if (x < -65535) x = -65535;
        if (y > 65535) y = 65535;
        if (y < -65535) y = -65535;
        v.x = x[CRD_W-1:0];
        v.y = y[CRD_W-1:0];
        v.last = 1'b0;
        v.empty = 1'b0;
        expected_verts = {expected_verts, v};
    endfunction

    function automatic void emit_arc(longint d, longint k, longint r, bit halved);
        longint      den;
        longint      m;
        logic [63:0] a64;
        logic [31:0] ang;
        logic [31:0] folded;
        logic [1:0]  quad;
        logic [31:0] resid;
        longint      z;
        longint      x;
        longint      y;
        longint      t;
        longint      cx;
        longint      cy;
        den = 12 * r;
        m = k % den;
        if (m < 0) m += den;
        a64 = ((64'(m) << 32) + 64'(den / 2)) / 64'(den);
        ang = a64[31:0];
        folded = ang + 32'h20000000;
        quad = folded[31:30];
        resid = ang - {quad, 30'b0};
        z = longint'($signed(resid));
        x = halved ? START_GAIN / 2 : START_GAIN;
        y = 0;
        for (int i = 0; i < TRIG_ITERATIONS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); x = t;
                z -= longint'(ATAN_TURNS[i]);
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); x = t;
                z += longint'(ATAN_TURNS[i]);
            end
        end
        case (quad)
            2'd0: begin cx = x;  cy = y;  end
            2'd1: begin cx = -y; cy = x;  end
            2'd2: begin cx = -x; cy = -y; end
            default: begin cx = y; cy = -x; end
        endcase
        emit_point(d, cx, cy);
    endfunction

    function automatic void predict_outline(logic [KIND_W-1:0] kind, logic [DIA_W-1:0] dia,
                                            logic [RES_W-1:0] res);
        longint  d;
        longint  r;
        longint  s;
        longint  yd;
        longint  yc;
        int      before_cnt;
        vertex_t v;
        d = dia;
        r = (res > MAX_POINTS) ? MAX_POINTS : res;
        before_cnt = expected_verts.size();
        if (r > 0) begin
            case (kind)
                KIND_CIRCLE:
                    for (longint i = 0; i < r; i++) emit_arc(d, 12 * i, r, 1'b1);
                KIND_SQUARE, KIND_RECT: begin
                    yd = (kind == KIND_SQUARE) ? 2 * r : 4 * r;
                    yc = (kind == KIND_SQUARE) ? Q30 / 2 : Q30 / 4;
                    s = r / 4;
                    for (longint i = 0; i < s; i++)
                        emit_point(d, Q30 / 2, rdiv(Q30 * (8 * i - r), yd));
                    for (longint i = 0; i < s; i++)
                        emit_point(d, rdiv(Q30 * (r - 8 * i), 2 * r), yc);
                    for (longint i = 0; i < s; i++)
                        emit_point(d, -Q30 / 2, rdiv(Q30 * (r - 8 * i), yd));
                    for (longint i = 0; i < s; i++)
                        emit_point(d, rdiv(Q30 * (8 * i - r), 2 * r), -yc);
                end
                KIND_TRIANGLE: begin
                    s = r / 3;
                    for (longint i = 0; i < s; i++)
                        emit_point(d, rdiv(Q30 * (2 * r - 9 * i), 2 * r), rdiv(HS3 * 3 * i, r));
                    for (longint i = 0; i < s; i++)
                        emit_point(d, -Q30 / 2, rdiv(HS3 * (r - 6 * i), r));
                    for (longint i = 0; i < s; i++)
                        emit_point(d, rdiv(Q30 * (9 * i - r), 2 * r),
                                   -rdiv(HS3 * (r - 3 * i), r));
                end
                KIND_THIRD: begin
                    s = r / 4;
                    for (longint i = 0; i < s; i++)
                        emit_point(d, 0, rdiv(Q30 * (r - 4 * i), r));
                    for (longint i = 0; i < s; i++)
                        emit_point(d, rdiv(HS3 * 4 * i, r), rdiv(Q30 * (-2 * i), r));
                    for (longint i = 0; i < r / 2; i++) emit_arc(d, 8 * i - r, r, 1'b0);
                end
                KIND_HALF: begin
                    for (longint i = 0; i < r / 3; i++)
                        emit_point(d, 0, rdiv(Q30 * (r - 6 * i), r));
                    for (longint i = 0; i < (2 * r) / 3; i++)
                        emit_arc(d, 9 * i - 3 * r, r, 1'b0);
                end
                default: ;
            endcase
        end
        if (expected_verts.size() == before_cnt) begin
            v.x = '0;
            v.y = '0;
            v.last = 1'b1;
            v.empty = 1'b1;
            expected_verts = {expected_verts, v};
        end else begin
            expected_verts[expected_verts.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void add_req(logic [KIND_W-1:0] kind, logic [DIA_W-1:0] dia,
                                    logic [RES_W-1:0] res);
        request_t q;
        q.kind = kind;
        q.dia = dia;
        q.res = res;
        pending_reqs = {pending_reqs, q};
    endfunction

    // drive requests
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !req_taken) begin
            s_axis_tvalid <= 1'b1;
        end else if (req_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            req_gap <= req_gap - 1;
        end else if (pending_reqs.size() > 0) begin
            request_t q;
            q = pending_reqs.pop_front();
            s_axis_tdata  <= {1'b0, q.res, q.dia};
            s_axis_tuser  <= q.kind;
            s_axis_tvalid <= 1'b1;
            req_gap <= pick_gap();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // stall the output side
    always @(negedge i_clk) begin
        if ($urandom_range(0, 399) == 0) calm <= ~calm;
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // predict on accepted requests, check returned words
    always @(posedge i_clk) begin
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_outline(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[22:16]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: x=%h y=%h last=%b empty=%b",
                             m_axis_tdata[16:0], m_axis_tdata[33:17], m_axis_tlast,
                             m_axis_tuser);
            end else begin
                vertex_t v;
                v = expected_verts.pop_front();
                if (m_axis_tdata[16:0] !== v.x || m_axis_tdata[33:17] !== v.y ||
                    m_axis_tlast !== v.last || m_axis_tuser !== v.empty) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%h y=%h last=%b empty=%b, ",
                                  "got x=%h y=%h last=%b empty=%b"},
                                 v.x, v.y, v.last, v.empty, m_axis_tdata[16:0],
                                 m_axis_tdata[33:17], m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int p;
        logic [KIND_W-1:0] kind;
        logic [DIA_W-1:0]  dia;
        logic [RES_W-1:0]  res;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;

        add_req(KIND_CIRCLE, 16'hFFFF, 7'd64);
        add_req(KIND_CIRCLE, 16'h0100, 7'd0);
        add_req(KIND_CIRCLE, 16'h0000, 7'd7);
        add_req(KIND_CIRCLE, 16'hFFFF, 7'd1);
        add_req(KIND_SQUARE, 16'hFFFF, 7'd4);
        add_req(KIND_SQUARE, 16'h0200, 7'd3);
        add_req(KIND_SQUARE, 16'h8000, 7'd127);
        add_req(KIND_RECT, 16'hFFFF, 7'd64);
        add_req(KIND_RECT, 16'h0180, 7'd5);
        add_req(KIND_TRIANGLE, 16'hFFFF, 7'd3);
        add_req(KIND_TRIANGLE, 16'h0100, 7'd2);
        add_req(KIND_TRIANGLE, 16'h1234, 7'd64);
        add_req(KIND_THIRD, 16'hFFFF, 7'd2);
        add_req(KIND_THIRD, 16'h0100, 7'd1);
        add_req(KIND_THIRD, 16'hABCD, 7'd64);
        add_req(KIND_HALF, 16'hFFFF, 7'd2);
        add_req(KIND_HALF, 16'h0100, 7'd1);
        add_req(KIND_HALF, 16'h5555, 7'd65);
        add_req(KIND_NONE, 16'hFFFF, 7'd64);
        add_req(3'd7, 16'hFFFF, 7'd127);
        add_req(KIND_HALF, 16'h0000, 7'd0);

        repeat (400) begin
            p = $urandom_range(0, 99);
            kind = (p < 95) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
            p = $urandom_range(0, 99);
            dia = (p < 8) ? 16'hFFFF : ((p < 12) ? 16'h0000 : 16'($urandom));
            p = $urandom_range(0, 99);
            if (p < 70) res = 7'($urandom_range(0, 12));
            else if (p < 95) res = 7'($urandom_range(13, 64));
            else res = 7'($urandom_range(65, 127));
            add_req(kind, dia, res);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_verts.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
